### src/assert_macros.svh
// Assertion macros shared by the RTL of the bit packer.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition holds at every edge outside reset.
`define VLBP_ASSERT(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define VLBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VLBP_ASSERT(lbl, clk, rst_n, cond, msg)
`define VLBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/vlbp_pkg.sv
// Types and constants for the variable-length bit packer.
// No dependencies.
package vlbp_pkg;

	localparam int WORD_BITS  = 64;
	localparam int CNT_W      = 7;   // holds 0..WORD_BITS
	localparam int POS_W      = 6;   // bit position inside a word
	localparam int BT_W       = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = 2;
	localparam int FCNT_W     = 3;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [CNT_W-1:0]     valid_bits;
		logic                 stream_last;
	} result_t;

	typedef struct packed {
		logic push_a;      // first result present
		logic push_b;      // second result present
		logic stream_end;  // final block end: state returns to a new stream
	} merge_ctl_t;

endpackage

### src/vlbp_merge.sv
// Shift-and-merge of one request into the pending bits, with word and flush decisions.
// Depends on vlbp_pkg.
module vlbp_merge
	import vlbp_pkg::*;
(
	input  logic [WORD_BITS-1:0] value,
	input  logic [CNT_W-1:0]     bit_count,
	input  logic                 block_end,
	input  logic [WORD_BITS-1:0] pend_bits,
	input  logic [POS_W-1:0]     pend_cnt,
	input  logic [BT_W-1:0]      blocks_done,
	input  logic [BT_W-1:0]      block_total,
	output logic [WORD_BITS-1:0] nxt_bits,
	output logic [POS_W-1:0]     nxt_cnt,
	output logic [BT_W-1:0]      nxt_blocks,
	output result_t              res_a,
	output result_t              res_b,
	output merge_ctl_t           ctl
);

	logic [CNT_W-1:0]       n_sat;
	logic [WORD_BITS-1:0]   v_mask;
	logic [2*WORD_BITS-1:0] win;
	logic [WORD_BITS-1:0]   lo;
	logic [WORD_BITS-1:0]   hi;
	logic [CNT_W-1:0]       total;
	logic                   full;
	logic [POS_W-1:0]       rem;
	logic [BT_W-1:0]        limit;
	logic [BT_W:0]          done_inc;
	logic                   final_end;

	always_comb begin
		n_sat = (bit_count > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : bit_count;
		if (n_sat[POS_W])
			v_mask = value;
		else
			v_mask = value & ((WORD_BITS'(1) << n_sat[POS_W-1:0]) - WORD_BITS'(1));

		win   = {{WORD_BITS{1'b0}}, v_mask} << pend_cnt;
		lo    = win[WORD_BITS-1:0] | pend_bits;
		hi    = win[2*WORD_BITS-1:WORD_BITS];
		total = {1'b0, pend_cnt} + n_sat;
		full  = total[POS_W];
		rem   = total[POS_W-1:0];

		limit     = (block_total == '0) ? BT_W'(1) : block_total;
		done_inc  = {1'b0, blocks_done} + (BT_W+1)'(1);
		final_end = block_end && (done_inc >= {1'b0, limit});

		// a full word leaves its upper half as the new remainder
		nxt_bits = final_end ? '0 : (full ? hi : lo);
		nxt_cnt  = final_end ? '0 : rem;
		if (!block_end)
			nxt_blocks = blocks_done;
		else if (final_end)
			nxt_blocks = '0;
		else
			nxt_blocks = done_inc[BT_W-1:0];

		if (full) begin
			res_a.word        = lo;
			res_a.valid_bits  = CNT_W'(WORD_BITS);
			res_a.stream_last = final_end && (rem == '0);
		end else begin
			// flush of the remainder; an empty remainder gives word 0, zero bits
			res_a.word        = lo;
			res_a.valid_bits  = {1'b0, rem};
			res_a.stream_last = 1'b1;
		end
		res_b.word        = hi;
		res_b.valid_bits  = {1'b0, rem};
		res_b.stream_last = 1'b1;

		ctl.push_a     = full || final_end;
		ctl.push_b     = full && final_end && (rem != '0);
		ctl.stream_end = final_end;
	end

endmodule

### src/vlbp_out_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per transaction.
// Depends on vlbp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vlbp_out_fifo
	import vlbp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_a,
	input  logic    push_b,
	input  result_t din_a,
	input  result_t din_b,
	output logic    room2,
	output logic    dout_valid,
	input  logic    dout_ready,
	output result_t dout
);

	result_t            mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0]  wp_q;
	logic [FPTR_W-1:0]  rp_q;
	logic [FCNT_W-1:0]  count_q;
	logic               pop;
	logic [FCNT_W-1:0]  n_push;

	assign dout_valid = (count_q != '0);
	assign dout       = mem_q[rp_q];
	assign pop        = dout_valid && dout_ready;
	assign room2      = (count_q <= FCNT_W'(FIFO_DEPTH - 2));
	assign n_push     = FCNT_W'(push_a) + FCNT_W'(push_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + FPTR_W'(n_push);
			rp_q    <= rp_q + FPTR_W'(pop);
			count_q <= count_q + n_push - FCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_a)
			mem_q[wp_q] <= din_a;
		if (push_b)
			mem_q[wp_q + FPTR_W'(1)] <= din_b;
	end

	`VLBP_ASSERT(a_fifo_bound, clk, arst_n, count_q <= FCNT_W'(FIFO_DEPTH), "result queue over depth")
	`VLBP_ASSERT(a_push_order, clk, arst_n, !push_b || push_a, "second result without first")
	`VLBP_ASSERT(a_no_overflow, clk, arst_n, !push_a || room2, "push into a queue without room")

endmodule

### src/variable_length_bit_packer.sv
// Variable-length bit packer, top level.
// Depends on vlbp_pkg, vlbp_merge, vlbp_out_fifo and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready): value, bit_count, block_end. The low
//   bit_count bits of value (counts above 64 act as 64) are appended LSB first
//   to one bit stream. Output channel (out_valid/out_ready): word, valid_bits,
//   stream_last; every 64 gathered bits leave as a full word, and the block end
//   of the last block of a stream flushes the remainder zero-padded, marked last.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes block_total, the number
//   of blocks per stream; cfg_ready is always high. Write it only while idle.
// Timing:
//   A request is held in the input register until the queue has room, then its
//   results enter a four-entry result queue whose oldest entry drives the
//   outputs. One request per clock is sustained while the queue has room for
//   two results; a request that yields two words needs two output
//   transactions, so the queue drain of one result per clock sets the rate.
// Reset clears the pending bits, block counter and queue; block_total becomes 1.
// When the receiver stalls, the queue fills and in_ready drops once fewer than
// two entries are free and the input register is occupied.
`include "assert_macros.svh"
module variable_length_bit_packer
	import vlbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [WORD_BITS-1:0] value,
	input  logic [CNT_W-1:0]     bit_count,
	input  logic                 block_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] word,
	output logic [CNT_W-1:0]     valid_bits,
	output logic                 stream_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [BT_W-1:0]      cfg_data
);

	logic                 s1_valid_q;
	logic [WORD_BITS-1:0] value_s1;
	logic [CNT_W-1:0]     count_s1;
	logic                 end_s1;

	logic [WORD_BITS-1:0] pend_bits_q;
	logic [POS_W-1:0]     pend_cnt_q;
	logic [BT_W-1:0]      blocks_done_q;
	logic [BT_W-1:0]      block_total_q;

	logic [WORD_BITS-1:0] nxt_bits;
	logic [POS_W-1:0]     nxt_cnt;
	logic [BT_W-1:0]      nxt_blocks;
	result_t              res_a;
	result_t              res_b;
	merge_ctl_t           ctl;
	result_t              dout;
	logic                 room2;
	logic                 commit;
	logic                 in_accept;
	logic [WORD_BITS-1:0] pend_mask;
	logic                 s1_stall;
	logic                 stream_done;
	logic                 state_idle;

	assign commit    = s1_valid_q && room2;
	assign in_ready  = !s1_valid_q || commit;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q    <= 1'b0;
			pend_bits_q   <= '0;
			pend_cnt_q    <= '0;
			blocks_done_q <= '0;
			block_total_q <= BT_W'(1);
		end else begin
			if (in_accept)
				s1_valid_q <= 1'b1;
			else if (commit)
				s1_valid_q <= 1'b0;
			if (commit) begin
				pend_bits_q   <= nxt_bits;
				pend_cnt_q    <= nxt_cnt;
				blocks_done_q <= nxt_blocks;
			end
			if (cfg_valid && cfg_ready)
				block_total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			value_s1 <= value;
			count_s1 <= bit_count;
			end_s1   <= block_end;
		end
	end

	vlbp_merge u_merge (
		.value       (value_s1),
		.bit_count   (count_s1),
		.block_end   (end_s1),
		.pend_bits   (pend_bits_q),
		.pend_cnt    (pend_cnt_q),
		.blocks_done (blocks_done_q),
		.block_total (block_total_q),
		.nxt_bits    (nxt_bits),
		.nxt_cnt     (nxt_cnt),
		.nxt_blocks  (nxt_blocks),
		.res_a       (res_a),
		.res_b       (res_b),
		.ctl         (ctl)
	);

	vlbp_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_a     (commit && ctl.push_a),
		.push_b     (commit && ctl.push_b),
		.din_a      (res_a),
		.din_b      (res_b),
		.room2      (room2),
		.dout_valid (out_valid),
		.dout_ready (out_ready),
		.dout       (dout)
	);

	assign word        = dout.word;
	assign valid_bits  = dout.valid_bits;
	assign stream_last = dout.stream_last;

	assign pend_mask   = (WORD_BITS'(1) << pend_cnt_q) - WORD_BITS'(1);
	assign s1_stall    = s1_valid_q && !commit;
	assign stream_done = commit && ctl.stream_end;
	assign state_idle  = (pend_cnt_q == '0) && (blocks_done_q == '0);

	`VLBP_ASSERT(a_ready_when_empty, clk, arst_n, s1_valid_q || in_ready, "input stalled")
	`VLBP_ASSERT_NEXT(a_stall_holds, clk, arst_n, s1_stall, s1_valid_q, "held transaction lost")
	`VLBP_ASSERT(a_pend_clean, clk, arst_n, (pend_bits_q & ~pend_mask) == '0, "bits above count")
	`VLBP_ASSERT_NEXT(a_end_clears, clk, arst_n, stream_done, state_idle, "stream end left state")

endmodule
